/* rtl/wws_pkg.sv */
// Wind window statistics: shared sizes, request codes, controller states
// and the command/status bundles between controller and datapath.
// No dependencies.
package wws_pkg;

  localparam int WINDOW_DEPTH = 64;

  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = 8 + CNT_W;
  localparam int DIVC_W  = $clog2(SUM_W + 1);

  localparam logic [7:0] INVALID_MARK  = 8'hFF;
  localparam logic [7:0] COUNT_MAX     = 8'd254;
  localparam logic [6:0] DIR_MAX       = 7'd100;
  localparam int         VALID_OUT_MAX = 127;

  typedef enum logic [1:0] {
    REQ_REV    = 2'd0,
    REQ_DIR    = 2'd1,
    REQ_STORE  = 2'd2,
    REQ_REPORT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPD_LOAD,
    ST_SPD_DIV,
    ST_DIR_LOAD,
    ST_DIR_DIV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic event_upd;   // apply a non-report request
    logic scan_start;
    logic scan_run;
    logic div_load;
    logic div_run;
    logic div_save;
    logic div_sel;     // 0 speed, 1 direction
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
  } status_t;

endpackage

/* rtl/wws_ctrl.sv */
// Wind window statistics controller: sequences scan, two divisions and
// the result load, and owns both stream handshakes.
// Depends on wws_pkg.
module wws_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output wws_pkg::cmd_t    cmd,
  input  wws_pkg::status_t status
);

  wws_pkg::state_t state;
  wws_pkg::state_t state_next;
  logic            accept;
  logic            out_free;

  assign s_axis_tready = (state == wws_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wws_pkg::ST_IDLE: begin
        if (accept && (s_axis_tuser == wws_pkg::REQ_REPORT)) begin
          state_next = wws_pkg::ST_SCAN;
        end
      end
      wws_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = wws_pkg::ST_SPD_LOAD;
        end
      end
      wws_pkg::ST_SPD_LOAD: state_next = wws_pkg::ST_SPD_DIV;
      wws_pkg::ST_SPD_DIV: begin
        if (status.div_done) begin
          state_next = wws_pkg::ST_DIR_LOAD;
        end
      end
      wws_pkg::ST_DIR_LOAD: state_next = wws_pkg::ST_DIR_DIV;
      wws_pkg::ST_DIR_DIV: begin
        if (status.div_done) begin
          state_next = wws_pkg::ST_RESULT;
        end
      end
      wws_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = wws_pkg::ST_IDLE;
        end
      end
      default: state_next = wws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      wws_pkg::ST_IDLE: begin
        cmd.event_upd  = accept && (s_axis_tuser != wws_pkg::REQ_REPORT);
        cmd.scan_start = accept && (s_axis_tuser == wws_pkg::REQ_REPORT);
      end
      wws_pkg::ST_SCAN:     cmd.scan_run = 1'b1;
      wws_pkg::ST_SPD_LOAD: cmd.div_load = 1'b1;
      wws_pkg::ST_SPD_DIV: begin
        cmd.div_run  = 1'b1;
        cmd.div_save = status.div_done;
      end
      wws_pkg::ST_DIR_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = 1'b1;
      end
      wws_pkg::ST_DIR_DIV: begin
        cmd.div_run  = 1'b1;
        cmd.div_save = status.div_done;
        cmd.div_sel  = 1'b1;
      end
      wws_pkg::ST_RESULT:   cmd.res_load = out_free;
      default: cmd = '0;
    endcase
  end

  // Hold the result word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

/* rtl/wws_datapath.sv */
// Wind window statistics datapath: period counters, the two ring memories,
// the scan accumulators, a shared restoring divider and the result register.
// Depends on wws_pkg.
module wws_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       req_type,
  input  logic [6:0]       direction_pct,
  input  wws_pkg::cmd_t    cmd,
  output wws_pkg::status_t status,
  output logic [31:0]      result
);

  localparam int SLOT_W = wws_pkg::SLOT_W;
  localparam int CNT_W  = wws_pkg::CNT_W;
  localparam int SUM_W  = wws_pkg::SUM_W;
  localparam int DIVC_W = wws_pkg::DIVC_W;

  logic [7:0]        speed_mem [wws_pkg::WINDOW_DEPTH];
  logic [6:0]        dir_mem   [wws_pkg::WINDOW_DEPTH];

  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill;
  logic [7:0]        rev_count;
  logic [6:0]        cur_dir;

  logic [CNT_W-1:0]  scan_addr;
  logic              rd_vld;
  logic [7:0]        rd_speed;
  logic [6:0]        rd_dir;
  logic [SUM_W-1:0]  speed_sum;
  logic [SUM_W-1:0]  dir_sum;
  logic [7:0]        peak;

  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [DIVC_W-1:0] div_cnt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic [7:0]        avg_speed;
  logic [6:0]        avg_dir;
  logic [6:0]        valid_out;

  // Entries fill in slot order, so the valid entries are slots 0..fill-1.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill       <= '0;
      rev_count  <= '0;
      cur_dir    <= '0;
    end else if (cmd.event_upd) begin
      case (req_type)
        wws_pkg::REQ_REV: begin
          if (rev_count < wws_pkg::COUNT_MAX) begin
            rev_count <= rev_count + 8'd1;
          end
        end
        wws_pkg::REQ_DIR: begin
          cur_dir <= (direction_pct > wws_pkg::DIR_MAX) ? wws_pkg::DIR_MAX : direction_pct;
        end
        wws_pkg::REQ_STORE: begin
          rev_count <= '0;
          if (write_slot == SLOT_W'(wws_pkg::WINDOW_DEPTH - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + SLOT_W'(1);
          end
          if (fill != CNT_W'(wws_pkg::WINDOW_DEPTH)) begin
            fill <= fill + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.event_upd && (req_type == wws_pkg::REQ_STORE)) begin
      speed_mem[write_slot] <= rev_count;
      dir_mem[write_slot]   <= cur_dir;
    end
    rd_speed <= speed_mem[scan_addr[SLOT_W-1:0]];
    rd_dir   <= dir_mem[scan_addr[SLOT_W-1:0]];
  end

  // Scan: issue one read a cycle and accumulate each word in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_vld <= (scan_addr != fill);
      if (scan_addr != fill) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      speed_sum <= '0;
      dir_sum   <= '0;
      peak      <= '0;
    end else if (cmd.scan_run && rd_vld) begin
      speed_sum <= speed_sum + SUM_W'(rd_speed);
      dir_sum   <= dir_sum + SUM_W'(rd_dir);
      if (rd_speed > peak) begin
        peak <= rd_speed;
      end
    end
  end

  assign status.scan_done = (scan_addr == fill) && !rd_vld;

  // Restoring division of the selected sum by the fill count, one bit a cycle.
  assign shifted = {rem, quo[SUM_W-1]};
  assign fits    = shifted >= {1'b0, fill};
  assign diff    = shifted - {1'b0, fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= DIVC_W'(SUM_W);
    end else if (cmd.div_run && (div_cnt != '0)) begin
      div_cnt <= div_cnt - DIVC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      quo <= cmd.div_sel ? dir_sum : speed_sum;
    end else if (cmd.div_run && (div_cnt != '0)) begin
      rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign status.div_done = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_save) begin
      if (cmd.div_sel) begin
        avg_dir <= (fill == '0) ? 7'd0 : quo[6:0];
      end else begin
        avg_speed <= (fill == '0) ? 8'd0 : quo[7:0];
      end
    end
  end

  always_comb begin
    if (32'(fill) > 32'(wws_pkg::VALID_OUT_MAX)) begin
      valid_out = 7'(wws_pkg::VALID_OUT_MAX);
    end else begin
      valid_out = 7'(fill);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result <= {2'b00, valid_out, avg_dir, peak, avg_speed};
    end
  end

endmodule

/* rtl/wind_window_stats.sv */
// Wind window statistics top level: controller plus datapath.
// Depends on wws_pkg, wws_ctrl and wws_datapath.
//
//  channel  dir  handshake              contents
//  s_axis   in   s_axis_tvalid/tready   tuser: req_type; tdata: direction_pct
//  m_axis   out  m_axis_tvalid/tready   tdata: speed/direction report
//
// Revolution, direction and store requests are applied on acceptance and leave the controller idle.
// A report scans the fill stored periods (up to 64), one ring read per cycle,
// then runs two bit-serial divisions of the SUM_W-bit (15-bit) sums through
// the single shared divider.
// Reset clears the counters and the fill count; ring contents need no clear.
// The report word waits in the output register; requests are taken meanwhile,
// and a following report is computed but then holds the input off until that
// word is taken.
module wind_window_stats (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] direction_pct, [7] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [7:0] avg_speed_count, [15:8] peak_speed_count,
                                      // [22:16] avg_direction_pct, [29:23] valid_periods
);

  wws_pkg::cmd_t    cmd;
  wws_pkg::status_t status;

  wws_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .status        (status)
  );

  wws_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .req_type      (s_axis_tuser),
    .direction_pct (s_axis_tdata[6:0]),
    .cmd           (cmd),
    .status        (status),
    .result        (m_axis_tdata)
  );

endmodule
